// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== rtl/core/wft_pkg.sv =====
// ----------------------------------------------------------------------------
// wft_pkg
// types, codes, microcode and arithmetic helpers for the wrench frame transform
// ----------------------------------------------------------------------------
package wft_pkg;

	// command codes
	localparam logic CMD_POSE   = 1'b0;
	localparam logic CMD_WRENCH = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_POSITION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_ROTATION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z     = 3'd4;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

	// datapath widths
	localparam int PROD_W = 64;
	localparam int TERM_W = 49;
	localparam int ACC_W  = 52;

	// payload types
	typedef struct packed {
		logic              cmd;
		logic signed [31:0] vec_a_x;
		logic signed [31:0] vec_a_y;
		logic signed [31:0] vec_a_z;
		logic signed [31:0] vec_b_w;
		logic signed [31:0] vec_b_x;
		logic signed [31:0] vec_b_y;
		logic signed [31:0] vec_b_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] force_out_x;
		logic signed [31:0] force_out_y;
		logic signed [31:0] force_out_z;
		logic signed [31:0] torque_out_x;
		logic signed [31:0] torque_out_y;
		logic signed [31:0] torque_out_z;
	} out_item_t;

	// multiplier operand a select
	localparam logic [3:0] ASEL_R00 = 4'd0;
	localparam logic [3:0] ASEL_R01 = 4'd1;
	localparam logic [3:0] ASEL_R02 = 4'd2;
	localparam logic [3:0] ASEL_R10 = 4'd3;
	localparam logic [3:0] ASEL_R11 = 4'd4;
	localparam logic [3:0] ASEL_R12 = 4'd5;
	localparam logic [3:0] ASEL_R20 = 4'd6;
	localparam logic [3:0] ASEL_R21 = 4'd7;
	localparam logic [3:0] ASEL_R22 = 4'd8;
	localparam logic [3:0] ASEL_P0  = 4'd9;
	localparam logic [3:0] ASEL_P1  = 4'd10;
	localparam logic [3:0] ASEL_P2  = 4'd11;
	localparam logic [3:0] ASEL_QW  = 4'd12;
	localparam logic [3:0] ASEL_QX  = 4'd13;
	localparam logic [3:0] ASEL_QY  = 4'd14;
	localparam logic [3:0] ASEL_QZ  = 4'd15;

	// multiplier operand b select
	localparam logic [3:0] BSEL_A0 = 4'd0;
	localparam logic [3:0] BSEL_A1 = 4'd1;
	localparam logic [3:0] BSEL_A2 = 4'd2;
	localparam logic [3:0] BSEL_S0 = 4'd3;
	localparam logic [3:0] BSEL_S1 = 4'd4;
	localparam logic [3:0] BSEL_S2 = 4'd5;
	localparam logic [3:0] BSEL_QW = 4'd6;
	localparam logic [3:0] BSEL_QX = 4'd7;
	localparam logic [3:0] BSEL_QY = 4'd8;
	localparam logic [3:0] BSEL_QZ = 4'd9;

	// rounding shift select
	localparam logic [1:0] SH_29 = 2'd0;
	localparam logic [1:0] SH_16 = 2'd1;
	localparam logic [1:0] SH_30 = 2'd2;

	// accumulator start value select
	localparam logic [2:0] INIT_ZERO = 3'd0;
	localparam logic [2:0] INIT_ONE  = 3'd1;
	localparam logic [2:0] INIT_B0   = 3'd2;
	localparam logic [2:0] INIT_B1   = 3'd3;
	localparam logic [2:0] INIT_B2   = 3'd4;

	// result destination
	localparam logic [4:0] DST_R00 = 5'd0;
	localparam logic [4:0] DST_R01 = 5'd1;
	localparam logic [4:0] DST_R02 = 5'd2;
	localparam logic [4:0] DST_R10 = 5'd3;
	localparam logic [4:0] DST_R11 = 5'd4;
	localparam logic [4:0] DST_R12 = 5'd5;
	localparam logic [4:0] DST_R20 = 5'd6;
	localparam logic [4:0] DST_R21 = 5'd7;
	localparam logic [4:0] DST_R22 = 5'd8;
	localparam logic [4:0] DST_S0  = 5'd9;
	localparam logic [4:0] DST_S1  = 5'd10;
	localparam logic [4:0] DST_S2  = 5'd11;
	localparam logic [4:0] DST_F0  = 5'd12;
	localparam logic [4:0] DST_F1  = 5'd13;
	localparam logic [4:0] DST_F2  = 5'd14;
	localparam logic [4:0] DST_T0  = 5'd15;
	localparam logic [4:0] DST_T1  = 5'd16;
	localparam logic [4:0] DST_T2  = 5'd17;

	// sequencer program layout
	localparam int STEP_W = 6;
	localparam logic [STEP_W-1:0] POSE_START   = 6'd0;
	localparam logic [STEP_W-1:0] WRENCH_START = 6'd18;

	typedef struct packed {
		logic [3:0] a_sel;
		logic [3:0] b_sel;
		logic [1:0] sh_sel;
		logic [2:0] init_sel;
		logic       neg;
		logic       first;
		logic       last;
		logic [4:0] dest;
		logic       fin;
	} ucode_t;

	function automatic ucode_t mk(input logic [3:0] a, input logic [3:0] b,
			input logic [1:0] sh, input logic [2:0] init, input logic neg,
			input logic first, input logic last, input logic [4:0] dest,
			input logic fin);
		ucode_t u;
		u.a_sel    = a;
		u.b_sel    = b;
		u.sh_sel   = sh;
		u.init_sel = init;
		u.neg      = neg;
		u.first    = first;
		u.last     = last;
		u.dest     = dest;
		u.fin      = fin;
		return u;
	endfunction

	// microprogram: pose matrix build, then wrench cross product and rotations
	function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
		ucode_t u;
		case (step)
			// r00 = 1 - 2yy - 2zz
			6'd0:  u = mk(ASEL_QY, BSEL_QY, SH_29, INIT_ONE,  1'b1, 1'b1, 1'b0, DST_R00, 1'b0);
			6'd1:  u = mk(ASEL_QZ, BSEL_QZ, SH_29, INIT_ZERO, 1'b1, 1'b0, 1'b1, DST_R00, 1'b0);
			// r01 = 2xy - 2wz
			6'd2:  u = mk(ASEL_QX, BSEL_QY, SH_29, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_R01, 1'b0);
			6'd3:  u = mk(ASEL_QW, BSEL_QZ, SH_29, INIT_ZERO, 1'b1, 1'b0, 1'b1, DST_R01, 1'b0);
			// r02 = 2xz + 2wy
			6'd4:  u = mk(ASEL_QX, BSEL_QZ, SH_29, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_R02, 1'b0);
			6'd5:  u = mk(ASEL_QW, BSEL_QY, SH_29, INIT_ZERO, 1'b0, 1'b0, 1'b1, DST_R02, 1'b0);
			// r10 = 2xy + 2wz
			6'd6:  u = mk(ASEL_QX, BSEL_QY, SH_29, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_R10, 1'b0);
			6'd7:  u = mk(ASEL_QW, BSEL_QZ, SH_29, INIT_ZERO, 1'b0, 1'b0, 1'b1, DST_R10, 1'b0);
			// r11 = 1 - 2xx - 2zz
			6'd8:  u = mk(ASEL_QX, BSEL_QX, SH_29, INIT_ONE,  1'b1, 1'b1, 1'b0, DST_R11, 1'b0);
			6'd9:  u = mk(ASEL_QZ, BSEL_QZ, SH_29, INIT_ZERO, 1'b1, 1'b0, 1'b1, DST_R11, 1'b0);
			// r12 = 2yz - 2wx
			6'd10: u = mk(ASEL_QY, BSEL_QZ, SH_29, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_R12, 1'b0);
			6'd11: u = mk(ASEL_QW, BSEL_QX, SH_29, INIT_ZERO, 1'b1, 1'b0, 1'b1, DST_R12, 1'b0);
			// r20 = 2xz - 2wy
			6'd12: u = mk(ASEL_QX, BSEL_QZ, SH_29, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_R20, 1'b0);
			6'd13: u = mk(ASEL_QW, BSEL_QY, SH_29, INIT_ZERO, 1'b1, 1'b0, 1'b1, DST_R20, 1'b0);
			// r21 = 2yz + 2wx
			6'd14: u = mk(ASEL_QY, BSEL_QZ, SH_29, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_R21, 1'b0);
			6'd15: u = mk(ASEL_QW, BSEL_QX, SH_29, INIT_ZERO, 1'b0, 1'b0, 1'b1, DST_R21, 1'b0);
			// r22 = 1 - 2xx - 2yy
			6'd16: u = mk(ASEL_QX, BSEL_QX, SH_29, INIT_ONE,  1'b1, 1'b1, 1'b0, DST_R22, 1'b0);
			6'd17: u = mk(ASEL_QY, BSEL_QY, SH_29, INIT_ZERO, 1'b1, 1'b0, 1'b1, DST_R22, 1'b1);
			// s0 = p1*f2 - p2*f1 + t0
			6'd18: u = mk(ASEL_P1, BSEL_A2, SH_16, INIT_B0,   1'b0, 1'b1, 1'b0, DST_S0,  1'b0);
			6'd19: u = mk(ASEL_P2, BSEL_A1, SH_16, INIT_ZERO, 1'b1, 1'b0, 1'b1, DST_S0,  1'b0);
			// s1 = p2*f0 - p0*f2 + t1
			6'd20: u = mk(ASEL_P2, BSEL_A0, SH_16, INIT_B1,   1'b0, 1'b1, 1'b0, DST_S1,  1'b0);
			6'd21: u = mk(ASEL_P0, BSEL_A2, SH_16, INIT_ZERO, 1'b1, 1'b0, 1'b1, DST_S1,  1'b0);
			// s2 = p0*f1 - p1*f0 + t2
			6'd22: u = mk(ASEL_P0, BSEL_A1, SH_16, INIT_B2,   1'b0, 1'b1, 1'b0, DST_S2,  1'b0);
			6'd23: u = mk(ASEL_P1, BSEL_A0, SH_16, INIT_ZERO, 1'b1, 1'b0, 1'b1, DST_S2,  1'b0);
			// force rotation
			6'd24: u = mk(ASEL_R00, BSEL_A0, SH_30, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_F0, 1'b0);
			6'd25: u = mk(ASEL_R01, BSEL_A1, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b0, DST_F0, 1'b0);
			6'd26: u = mk(ASEL_R02, BSEL_A2, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b1, DST_F0, 1'b0);
			6'd27: u = mk(ASEL_R10, BSEL_A0, SH_30, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_F1, 1'b0);
			6'd28: u = mk(ASEL_R11, BSEL_A1, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b0, DST_F1, 1'b0);
			6'd29: u = mk(ASEL_R12, BSEL_A2, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b1, DST_F1, 1'b0);
			6'd30: u = mk(ASEL_R20, BSEL_A0, SH_30, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_F2, 1'b0);
			6'd31: u = mk(ASEL_R21, BSEL_A1, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b0, DST_F2, 1'b0);
			6'd32: u = mk(ASEL_R22, BSEL_A2, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b1, DST_F2, 1'b0);
			// torque rotation
			6'd33: u = mk(ASEL_R00, BSEL_S0, SH_30, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_T0, 1'b0);
			6'd34: u = mk(ASEL_R01, BSEL_S1, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b0, DST_T0, 1'b0);
			6'd35: u = mk(ASEL_R02, BSEL_S2, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b1, DST_T0, 1'b0);
			6'd36: u = mk(ASEL_R10, BSEL_S0, SH_30, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_T1, 1'b0);
			6'd37: u = mk(ASEL_R11, BSEL_S1, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b0, DST_T1, 1'b0);
			6'd38: u = mk(ASEL_R12, BSEL_S2, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b1, DST_T1, 1'b0);
			6'd39: u = mk(ASEL_R20, BSEL_S0, SH_30, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_T2, 1'b0);
			6'd40: u = mk(ASEL_R21, BSEL_S1, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b0, DST_T2, 1'b0);
			6'd41: u = mk(ASEL_R22, BSEL_S2, SH_30, INIT_ZERO, 1'b0, 1'b0, 1'b1, DST_T2, 1'b1);
			default: u = mk(ASEL_R00, BSEL_A0, SH_30, INIT_ZERO, 1'b0, 1'b1, 1'b0, DST_R00,
				1'b1);
		endcase
		return u;
	endfunction

	// clamp the accumulator to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sd2147483647);
		lo = ACC_W'(-64'sd2147483648);
		if (v > hi)
			return 32'sh7fff_ffff;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

// ===== rtl/core/wrench_frame_transform.sv =====
// ----------------------------------------------------------------------------
// wrench_frame_transform
// moves a force/torque sample into another frame with one shared multiplier
// ----------------------------------------------------------------------------
// A pose transaction (cmd 0) loads the lever arm and the rotation matrix and
// returns nothing; a wrench transaction (cmd 1) returns one result with
// force' = R*f and torque' = R*(p x f + t), Q16.16 in and out, matrix Q2.30.
// All products go through a single 32x32 multiplier under a microcoded
// sequencer, one product per cycle unless held by an untaken result, followed
// by a rounding stage and an accumulate/saturate stage. A pose with rotation
// use on takes 18 multiplier steps, and in_stall stays high until the last step
// reaches the accumulate stage; a pose with rotation use off is done at
// acceptance. A wrench takes 24 multiplier steps and drains the same way; its
// steps issue only while the output register is empty, so a result that has
// not been taken holds them. Results are held in an output register until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wrench_frame_transform (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [wft_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                         cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  wft_pkg::in_item_t                   in_data,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output wft_pkg::out_item_t                  out_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	// configuration registers
	logic                use_position_q;
	logic                use_rotation_q;
	logic signed [31:0]  offset_q [3];

	// block state
	logic signed [31:0]  rm_q [9];
	logic signed [31:0]  lever_q [3];
	logic signed [31:0]  s_q [3];

	// captured item
	logic signed [31:0]  a_q [3];
	logic signed [31:0]  b_q [3];
	logic signed [31:0]  w_q;
	logic                wr_q;

	// sequencer
	logic [1:0]                    state_q;
	logic [wft_pkg::STEP_W-1:0]    step_q;
	wft_pkg::ucode_t               uc;
	logic                          issue;
	logic                          in_acc;
	logic                          pose_build;

	// datapath pipeline
	logic signed [31:0]                 op_a;
	logic signed [31:0]                 op_b;
	logic signed [wft_pkg::PROD_W-1:0]  prod_s1;
	wft_pkg::ucode_t                    ctl_s1;
	logic                               v_s1;
	logic signed [wft_pkg::PROD_W:0]    rnd_sum;
	logic signed [wft_pkg::PROD_W:0]    rnd_shf;
	logic signed [wft_pkg::TERM_W-1:0]  term_s2;
	wft_pkg::ucode_t                    ctl_s2;
	logic                               v_s2;
	logic signed [wft_pkg::ACC_W-1:0]   acc_q;
	logic signed [wft_pkg::ACC_W-1:0]   acc_base;
	logic signed [wft_pkg::ACC_W-1:0]   acc_term;
	logic signed [wft_pkg::ACC_W-1:0]   acc_next;
	logic signed [31:0]                 acc_sat;
	logic                               wr_en;
	logic                               res_wr;
	logic                               res_last;

	// output register
	logic                out_valid_q;
	wft_pkg::out_item_t  out_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// pose that starts a matrix build
	assign pose_build = in_acc && (in_data.cmd == wft_pkg::CMD_POSE) && use_rotation_q;

	// microcode fetch and issue gate
	assign uc    = wft_pkg::ucode(step_q);
	assign issue = (state_q == ST_ISSUE) && !(wr_q && out_valid_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_position_q <= 1'b1;
			use_rotation_q <= 1'b1;
			offset_q[0]    <= '0;
			offset_q[1]    <= '0;
			offset_q[2]    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wft_pkg::CFG_USE_POSITION: use_position_q <= cfg_data[0];
				wft_pkg::CFG_USE_ROTATION: use_rotation_q <= cfg_data[0];
				wft_pkg::CFG_OFFSET_X:     offset_q[0]    <= cfg_data;
				wft_pkg::CFG_OFFSET_Y:     offset_q[1]    <= cfg_data;
				wft_pkg::CFG_OFFSET_Z:     offset_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			wr_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						wr_q <= (in_data.cmd == wft_pkg::CMD_WRENCH);
						if (in_data.cmd == wft_pkg::CMD_WRENCH) begin
							step_q  <= wft_pkg::WRENCH_START;
							state_q <= ST_ISSUE;
						end else if (use_rotation_q) begin
							step_q  <= wft_pkg::POSE_START;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					if (issue) begin
						step_q <= step_q + wft_pkg::STEP_W'(1);
						if (uc.fin)
							state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s2 && ctl_s2.fin)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the item fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q[0] <= in_data.vec_a_x;
			a_q[1] <= in_data.vec_a_y;
			a_q[2] <= in_data.vec_a_z;
			b_q[0] <= in_data.vec_b_x;
			b_q[1] <= in_data.vec_b_y;
			b_q[2] <= in_data.vec_b_z;
			w_q    <= in_data.vec_b_w;
		end
	end

	// operand a select
	always_comb begin
		case (uc.a_sel)
			wft_pkg::ASEL_R00: op_a = rm_q[0];
			wft_pkg::ASEL_R01: op_a = rm_q[1];
			wft_pkg::ASEL_R02: op_a = rm_q[2];
			wft_pkg::ASEL_R10: op_a = rm_q[3];
			wft_pkg::ASEL_R11: op_a = rm_q[4];
			wft_pkg::ASEL_R12: op_a = rm_q[5];
			wft_pkg::ASEL_R20: op_a = rm_q[6];
			wft_pkg::ASEL_R21: op_a = rm_q[7];
			wft_pkg::ASEL_R22: op_a = rm_q[8];
			wft_pkg::ASEL_P0:  op_a = lever_q[0];
			wft_pkg::ASEL_P1:  op_a = lever_q[1];
			wft_pkg::ASEL_P2:  op_a = lever_q[2];
			wft_pkg::ASEL_QW:  op_a = w_q;
			wft_pkg::ASEL_QX:  op_a = b_q[0];
			wft_pkg::ASEL_QY:  op_a = b_q[1];
			wft_pkg::ASEL_QZ:  op_a = b_q[2];
			default:           op_a = '0;
		endcase
	end

	// operand b select
	always_comb begin
		case (uc.b_sel)
			wft_pkg::BSEL_A0: op_b = a_q[0];
			wft_pkg::BSEL_A1: op_b = a_q[1];
			wft_pkg::BSEL_A2: op_b = a_q[2];
			wft_pkg::BSEL_S0: op_b = s_q[0];
			wft_pkg::BSEL_S1: op_b = s_q[1];
			wft_pkg::BSEL_S2: op_b = s_q[2];
			wft_pkg::BSEL_QW: op_b = w_q;
			wft_pkg::BSEL_QX: op_b = b_q[0];
			wft_pkg::BSEL_QY: op_b = b_q[1];
			wft_pkg::BSEL_QZ: op_b = b_q[2];
			default:          op_b = '0;
		endcase
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// stage 1: shared multiplier
	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= op_a * op_b;
			ctl_s1  <= uc;
		end
	end

	// stage 2: round half up and shift
	always_comb begin
		case (ctl_s1.sh_sel)
			wft_pkg::SH_29: begin
				rnd_sum = {prod_s1[wft_pkg::PROD_W-1], prod_s1}
					+ (wft_pkg::PROD_W+1)'(65'sd1 <<< 28);
				rnd_shf = rnd_sum >>> 29;
			end
			wft_pkg::SH_16: begin
				rnd_sum = {prod_s1[wft_pkg::PROD_W-1], prod_s1}
					+ (wft_pkg::PROD_W+1)'(65'sd1 <<< 15);
				rnd_shf = rnd_sum >>> 16;
			end
			default: begin
				rnd_sum = {prod_s1[wft_pkg::PROD_W-1], prod_s1}
					+ (wft_pkg::PROD_W+1)'(65'sd1 <<< 29);
				rnd_shf = rnd_sum >>> 30;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			term_s2 <= rnd_shf[wft_pkg::TERM_W-1:0];
			ctl_s2  <= ctl_s1;
		end
	end

	// stage 3: accumulate and saturate
	always_comb begin
		if (ctl_s2.first) begin
			case (ctl_s2.init_sel)
				wft_pkg::INIT_ONE: acc_base = wft_pkg::ACC_W'(wft_pkg::ONE_Q30);
				wft_pkg::INIT_B0:  acc_base = wft_pkg::ACC_W'(b_q[0]);
				wft_pkg::INIT_B1:  acc_base = wft_pkg::ACC_W'(b_q[1]);
				wft_pkg::INIT_B2:  acc_base = wft_pkg::ACC_W'(b_q[2]);
				default:           acc_base = '0;
			endcase
		end else begin
			acc_base = acc_q;
		end
		acc_term = wft_pkg::ACC_W'(term_s2);
		acc_next = ctl_s2.neg ? (acc_base - acc_term) : (acc_base + acc_term);
		acc_sat  = wft_pkg::sat32(acc_next);
		wr_en    = v_s2 && ctl_s2.last;
	end

	// result field writes and the last one of a wrench
	assign res_wr = wr_en && (ctl_s2.dest inside {wft_pkg::DST_F0, wft_pkg::DST_F1,
		wft_pkg::DST_F2, wft_pkg::DST_T0, wft_pkg::DST_T1, wft_pkg::DST_T2});
	assign res_last = wr_en && (ctl_s2.dest == wft_pkg::DST_T2);

	always_ff @(posedge clk) begin
		if (v_s2)
			acc_q <= acc_next;
	end

	// matrix and lever arm: pose loads and matrix entry writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rm_q[0]    <= wft_pkg::ONE_Q30;
			rm_q[1]    <= '0;
			rm_q[2]    <= '0;
			rm_q[3]    <= '0;
			rm_q[4]    <= wft_pkg::ONE_Q30;
			rm_q[5]    <= '0;
			rm_q[6]    <= '0;
			rm_q[7]    <= '0;
			rm_q[8]    <= wft_pkg::ONE_Q30;
			lever_q[0] <= '0;
			lever_q[1] <= '0;
			lever_q[2] <= '0;
		end else begin
			if (in_acc && in_data.cmd == wft_pkg::CMD_POSE) begin
				if (use_position_q) begin
					lever_q[0] <= in_data.vec_a_x;
					lever_q[1] <= in_data.vec_a_y;
					lever_q[2] <= in_data.vec_a_z;
				end else begin
					lever_q[0] <= offset_q[0];
					lever_q[1] <= offset_q[1];
					lever_q[2] <= offset_q[2];
				end
				if (!use_rotation_q) begin
					rm_q[0] <= wft_pkg::ONE_Q30;
					rm_q[1] <= '0;
					rm_q[2] <= '0;
					rm_q[3] <= '0;
					rm_q[4] <= wft_pkg::ONE_Q30;
					rm_q[5] <= '0;
					rm_q[6] <= '0;
					rm_q[7] <= '0;
					rm_q[8] <= wft_pkg::ONE_Q30;
				end
			end
			if (wr_en) begin
				case (ctl_s2.dest)
					wft_pkg::DST_R00: rm_q[0] <= acc_sat;
					wft_pkg::DST_R01: rm_q[1] <= acc_sat;
					wft_pkg::DST_R02: rm_q[2] <= acc_sat;
					wft_pkg::DST_R10: rm_q[3] <= acc_sat;
					wft_pkg::DST_R11: rm_q[4] <= acc_sat;
					wft_pkg::DST_R12: rm_q[5] <= acc_sat;
					wft_pkg::DST_R20: rm_q[6] <= acc_sat;
					wft_pkg::DST_R21: rm_q[7] <= acc_sat;
					wft_pkg::DST_R22: rm_q[8] <= acc_sat;
					default: ;
				endcase
			end
		end
	end

	// cross product terms and result fields
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (ctl_s2.dest)
				wft_pkg::DST_S0: s_q[0]             <= acc_sat;
				wft_pkg::DST_S1: s_q[1]             <= acc_sat;
				wft_pkg::DST_S2: s_q[2]             <= acc_sat;
				wft_pkg::DST_F0: out_q.force_out_x  <= acc_sat;
				wft_pkg::DST_F1: out_q.force_out_y  <= acc_sat;
				wft_pkg::DST_F2: out_q.force_out_z  <= acc_sat;
				wft_pkg::DST_T0: out_q.torque_out_x <= acc_sat;
				wft_pkg::DST_T1: out_q.torque_out_y <= acc_sat;
				wft_pkg::DST_T2: out_q.torque_out_z <= acc_sat;
				default: ;
			endcase
		end
	end

	// output transaction valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_last)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// checks
	`ASSERT_IMP(a_idle_pipe_empty, clk, arst_n, state_q == ST_IDLE, !v_s1 && !v_s2)
	`ASSERT_NXT(a_last_torque_sets_valid, clk, arst_n, res_last, out_valid_q)
	`ASSERT_IMP(a_no_result_overwrite, clk, arst_n, res_wr, !out_valid_q)
	`ASSERT_NXT(a_pose_rot_starts, clk, arst_n, pose_build, state_q == ST_ISSUE)

endmodule
